// ----- sv/hcbd_pkg.sv -----
// Shared types, constants and helper functions for the HTTP chunked body decoder.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps

package hcbd_pkg;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_SIZE_LIMIT    = 2'd0;
    localparam logic [1:0] REG_TRAILER_LIMIT = 2'd1;
    localparam logic [1:0] REG_SKIP_LIMIT    = 2'd2;

    // Register widths and reset values
    localparam int SIZE_LIMIT_W    = 13;
    localparam int TRAILER_LIMIT_W = 14;
    localparam int SKIP_LIMIT_W    = 7;

    localparam logic [SIZE_LIMIT_W-1:0]    SIZE_LIMIT_RST    = 13'd1024;
    localparam logic [TRAILER_LIMIT_W-1:0] TRAILER_LIMIT_RST = 14'd4096;
    localparam logic [SKIP_LIMIT_W-1:0]    SKIP_LIMIT_RST    = 7'd8;

    // Line byte counter must reach the largest limit
    localparam int LINE_CNT_W = TRAILER_LIMIT_W;
    typedef logic [LINE_CNT_W-1:0] t_line_cnt;

    // Character codes
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum logic [2:0] {
        PH_SIZE_FIRST  = 3'd0,
        PH_SIZE_SECOND = 3'd1,
        PH_DATA        = 3'd2,
        PH_SKIP        = 3'd3,
        PH_TRAILER     = 3'd4,
        PH_DONE        = 3'd5,
        PH_FAILED      = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_BAD_HEX   = 2'd1,
        FAULT_LINE_LONG = 2'd2,
        FAULT_OVERFLOW  = 2'd3
    } t_fault;

    typedef struct packed {
        logic digit;    // a hex digit has been seen
        logic tail;     // whitespace after the digits
        logic ext;      // inside the extension after ';'
        logic leadcr;   // first byte of the line was CR
    } t_line_flags;

    typedef struct packed {
        logic [SIZE_LIMIT_W-1:0]    size_limit;
        logic [TRAILER_LIMIT_W-1:0] trailer_limit;
        logic [SKIP_LIMIT_W-1:0]    skip_limit;
    } t_limits;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload;
        t_fault     fault;
    } t_result;

    // Hex digit decode: {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'b0_0000;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            r = {1'b1, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            r = {1'b1, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

// ----- sv/hcbd_cfg.sv -----
// Configuration register bank on the APB-style port: the three line limits.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps

module hcbd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcbd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [hcbd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [hcbd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output hcbd_pkg::t_limits              o_limits
);
    import hcbd_pkg::*;

    t_limits    r_limits;
    logic       w_write;
    logic [1:0] w_index;

    assign pready  = 1'b1;
    assign w_index = paddr[3:2];
    assign w_write = psel & penable & pwrite & pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.size_limit    <= SIZE_LIMIT_RST;
            r_limits.trailer_limit <= TRAILER_LIMIT_RST;
            r_limits.skip_limit    <= SKIP_LIMIT_RST;
        end else if (w_write) begin
            case (w_index)
                REG_SIZE_LIMIT:    r_limits.size_limit    <= pwdata[SIZE_LIMIT_W-1:0];
                REG_TRAILER_LIMIT: r_limits.trailer_limit <= pwdata[TRAILER_LIMIT_W-1:0];
                REG_SKIP_LIMIT:    r_limits.skip_limit    <= pwdata[SKIP_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        case (w_index)
            REG_SIZE_LIMIT:    prdata = CFG_DATA_W'(r_limits.size_limit);
            REG_TRAILER_LIMIT: prdata = CFG_DATA_W'(r_limits.trailer_limit);
            REG_SKIP_LIMIT:    prdata = CFG_DATA_W'(r_limits.skip_limit);
            default:           prdata = '0;
        endcase
    end

    assign o_limits = r_limits;

endmodule

// ----- sv/hcbd_core.sv -----
// Per-byte parser: decoder state registers and the combinational step logic.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps

module hcbd_core #(
    parameter int CHUNK_SIZE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_start,
    input  hcbd_pkg::t_limits i_limits,
    output logic              o_res_valid,
    output hcbd_pkg::t_result o_result
);
    import hcbd_pkg::*;

    localparam int N = CHUNK_SIZE_BITS;

    t_phase      r_phase,  n_phase;
    logic [N-1:0] r_left,  n_left;
    logic [N-1:0] r_accum, n_accum;
    t_line_cnt   r_count,  n_count;
    t_line_flags r_flags,  n_flags;

    // State as seen by this byte (start_body clears it first)
    t_phase       w_phase;
    logic [N-1:0] w_left;
    logic [N-1:0] w_accum;
    t_line_cnt    w_count;
    t_line_flags  w_flags;

    logic         w_lf, w_ws, w_cr, w_semi;
    logic [4:0]   w_hex;
    logic         w_empty, w_over, w_acc_ovf, w_left_last;
    t_line_cnt    w_limit, w_count_inc;

    always_comb begin
        if (i_start) begin
            w_phase = PH_SIZE_FIRST;
            w_left  = '0;
            w_accum = '0;
            w_count = '0;
            w_flags = '0;
        end else begin
            w_phase = r_phase;
            w_left  = r_left;
            w_accum = r_accum;
            w_count = r_count;
            w_flags = r_flags;
        end
    end

    // Byte and line decode
    assign w_lf   = (i_byte == CH_LF);
    assign w_cr   = (i_byte == CH_CR);
    assign w_semi = (i_byte == CH_SEMI);
    assign w_ws   = (i_byte == CH_SP) || (i_byte == CH_TAB) || w_cr;
    assign w_hex  = hex_decode(i_byte);

    assign w_empty = (w_count == '0) || ((w_count == t_line_cnt'(1)) && w_flags.leadcr);
    assign w_count_inc = w_count + t_line_cnt'(1);
    assign w_acc_ovf   = (w_accum[N-1 -: 4] != 4'h0);
    assign w_left_last = (w_left == N'(1));

    // Limit for the line being read
    always_comb begin
        case (w_phase)
            PH_SIZE_FIRST, PH_SIZE_SECOND: w_limit = t_line_cnt'(i_limits.size_limit);
            PH_SKIP:                       w_limit = t_line_cnt'(i_limits.skip_limit);
            default:                       w_limit = i_limits.trailer_limit;
        endcase
    end
    assign w_over = (w_count >= w_limit);

    // Next state
    always_comb begin
        n_phase = w_phase;
        n_left  = w_left;
        n_accum = w_accum;
        n_count = w_count;
        n_flags = w_flags;
        case (w_phase)
            PH_SIZE_FIRST, PH_SIZE_SECOND: begin
                if (w_lf) begin
                    if (w_phase == PH_SIZE_FIRST && w_empty) begin
                        n_phase = PH_SIZE_SECOND;
                    end else if (w_accum == '0) begin
                        n_phase = PH_TRAILER;
                    end else begin
                        n_left  = w_accum;
                        n_phase = PH_DATA;
                    end
                    n_accum = '0;
                    n_count = '0;
                    n_flags = '0;
                end else if (w_over) begin
                    n_phase = PH_FAILED;
                end else begin
                    n_count = w_count_inc;
                    if (w_flags.ext) begin
                        n_flags = w_flags;
                    end else if (w_semi) begin
                        n_flags.ext = 1'b1;
                    end else if (w_ws) begin
                        if (w_flags.digit) begin
                            n_flags.tail = 1'b1;
                        end else if (w_count == '0 && w_cr) begin
                            n_flags.leadcr = 1'b1;
                        end
                    end else if (!w_hex[4] || w_flags.tail || w_acc_ovf) begin
                        n_phase = PH_FAILED;
                    end else begin
                        n_accum       = {w_accum[N-5:0], w_hex[3:0]};
                        n_flags.digit = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                n_left = w_left - N'(1);
                if (w_left_last) begin
                    n_phase = PH_SKIP;
                    n_accum = '0;
                    n_count = '0;
                    n_flags = '0;
                end
            end
            PH_SKIP: begin
                if (w_lf) begin
                    n_phase = PH_SIZE_FIRST;
                    n_accum = '0;
                    n_count = '0;
                    n_flags = '0;
                end else if (w_over) begin
                    n_phase = PH_FAILED;
                end else begin
                    n_count = w_count_inc;
                end
            end
            PH_TRAILER: begin
                if (w_lf) begin
                    if (w_empty) begin
                        n_phase = PH_DONE;
                    end
                    n_accum = '0;
                    n_count = '0;
                    n_flags = '0;
                end else if (w_over) begin
                    n_phase = PH_FAILED;
                end else begin
                    n_count = w_count_inc;
                    if (w_count == '0 && w_cr) begin
                        n_flags.leadcr = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Result for this byte
    always_comb begin
        o_res_valid      = 1'b0;
        o_result.kind    = KIND_PAYLOAD;
        o_result.payload = 8'h00;
        o_result.fault   = FAULT_NONE;
        case (w_phase)
            PH_SIZE_FIRST, PH_SIZE_SECOND: begin
                if (!w_lf) begin
                    if (w_over) begin
                        o_res_valid    = 1'b1;
                        o_result.kind  = KIND_ERROR;
                        o_result.fault = FAULT_LINE_LONG;
                    end else if (!w_flags.ext && !w_semi && !w_ws) begin
                        if (!w_hex[4] || w_flags.tail) begin
                            o_res_valid    = 1'b1;
                            o_result.kind  = KIND_ERROR;
                            o_result.fault = FAULT_BAD_HEX;
                        end else if (w_acc_ovf) begin
                            o_res_valid    = 1'b1;
                            o_result.kind  = KIND_ERROR;
                            o_result.fault = FAULT_OVERFLOW;
                        end
                    end
                end
            end
            PH_DATA: begin
                o_res_valid      = 1'b1;
                o_result.payload = i_byte;
            end
            PH_SKIP: begin
                if (!w_lf && w_over) begin
                    o_res_valid    = 1'b1;
                    o_result.kind  = KIND_ERROR;
                    o_result.fault = FAULT_LINE_LONG;
                end
            end
            PH_TRAILER: begin
                if (w_lf && w_empty) begin
                    o_res_valid   = 1'b1;
                    o_result.kind = KIND_DONE;
                end else if (!w_lf && w_over) begin
                    o_res_valid    = 1'b1;
                    o_result.kind  = KIND_ERROR;
                    o_result.fault = FAULT_LINE_LONG;
                end
            end
            default: ;
        endcase
    end

    // State registers, updated once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE_FIRST;
            r_left  <= '0;
            r_accum <= '0;
            r_count <= '0;
            r_flags <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_accum <= n_accum;
            r_count <= n_count;
            r_flags <= n_flags;
        end
    end

`ifndef NO_ASSERTIONS
    // An error always parks the parser in the failed phase
    a_err_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_result.kind == KIND_ERROR) |=> (r_phase == PH_FAILED))
        else $error("error result without entering failed phase");

    // Terminal phases stay silent until a new body starts
    a_terminal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_start && (r_phase == PH_DONE || r_phase == PH_FAILED))
            |-> !o_res_valid)
        else $error("result produced after body end");

    // Chunk data is only ever entered with bytes still due
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_left != '0))
        else $error("data phase with zero bytes left");

    // The skip-line counter never runs past the skip limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !w_lf && w_phase == PH_SKIP) |=> (r_count <= t_line_cnt'(i_limits.skip_limit)))
        else $error("skip counter beyond limit");
`endif

endmodule

// ----- sv/http_chunked_body_decoder.sv -----
// HTTP/1.1 chunked decoder, one byte/clock unless stalled; payload, end and error results.
// Top level. Depends on hcbd_pkg, hcbd_cfg and hcbd_core.
`timescale 1ns / 1ps

// Takes one byte of a chunked body per request on the input channel and sustains one byte
// per clock while results are taken. Each byte passes an input register, parse logic (hex
// accumulate, chunk byte countdown of CHUNK_SIZE_BITS bits, line-length check) and a
// result register. A byte moves on once the result slot is free or being drained, and its
// result is held there until the output takes it. A byte that gives no result still waits
// behind a result that has not been taken.
// A byte gives at most one result: a payload byte, a body-complete marker or an error.
// After completion or an error, bytes are swallowed until one arrives with start_body set.
// Write limits over the APB-style port only while idle; the block does not enforce it.
module http_chunked_body_decoder #(
    parameter int CHUNK_SIZE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Body byte channel
    input  logic                            i_body_valid,
    output logic                            o_body_ready,
    input  logic [7:0]                      i_body_byte,
    input  logic                            i_start_body,
    // Result channel
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic [1:0]                      o_kind,
    output logic [7:0]                      o_payload,
    output logic [1:0]                      o_fault,
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hcbd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [hcbd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [hcbd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import hcbd_pkg::*;

    t_limits    w_limits;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_advance;
    logic       w_res_valid;
    t_result    w_result;

    hcbd_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_limits (w_limits)
    );

    // Held byte moves on when the result slot is free or being drained
    assign w_advance    = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_body_ready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_body_ready) begin
            r_in_valid <= i_body_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_body_ready && i_body_valid) begin
            r_in_byte  <= i_body_byte;
            r_in_start <= i_start_body;
        end
    end

    hcbd_core #(
        .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_limits    (w_limits),
        .o_res_valid (w_res_valid),
        .o_result    (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res_valid;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_result;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_kind      = r_out.kind;
    assign o_payload   = r_out.payload;
    assign o_fault     = r_out.fault;

`ifndef NO_ASSERTIONS
    // A held byte is never dropped or replaced while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)
            && $stable(r_in_start)))
        else $error("pending byte lost");

    // A pending result is never overwritten before it is taken
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |-> !w_advance)
        else $error("result register overwritten");

    // Only payload results carry data; only errors carry a fault code
    a_out_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.kind == KIND_ERROR) == (r_out.fault != FAULT_NONE))
            && (r_out.kind == KIND_PAYLOAD || r_out.payload == 8'h00))
        else $error("inconsistent result fields");
`endif

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for http_chunked_body_decoder: directed bodies, limit faults,
// output back-pressure and long random runs. Depends on hcbd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb;
    import hcbd_pkg::*;

    localparam int SIZE_BITS    = 32;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_LEN     = 300;

    typedef struct packed {
        logic [7:0] b;
        logic       s;
    } t_body_req;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #6 i_clk = ~i_clk;

    // DUT side signals
    logic                  byte_valid = 1'b0;
    logic                  byte_ready;
    logic [7:0]            byte_data  = 8'h00;
    logic                  byte_start = 1'b0;
    logic                  res_valid;
    logic                  res_ready  = 1'b0;
    logic [1:0]            res_kind;
    logic [7:0]            res_payload;
    logic [1:0]            res_fault;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    http_chunked_body_decoder #(
        .CHUNK_SIZE_BITS(SIZE_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_body_valid (byte_valid),
        .o_body_ready (byte_ready),
        .i_body_byte  (byte_data),
        .i_start_body (byte_start),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_kind       (res_kind),
        .o_payload    (res_payload),
        .o_fault      (res_fault),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Bench bookkeeping
    t_body_req pending[$];
    t_result   due_results[$];
    logic      next_start  = 1'b0;
    int        tx_idle_max = 0;
    int        rx_idle_max = 0;
    int        hold_cycles = 0;
    int        mismatches  = 0;
    int        sent_items  = 0;
    int        cycle_count = 0;

    // Decoder model state and limits
    t_phase                     ph;
    logic [63:0]                chunk_left;
    logic [63:0]                size_acc;
    int unsigned                line_len;
    t_line_flags                lflags;
    logic [SIZE_LIMIT_W-1:0]    lim_size    = SIZE_LIMIT_RST;
    logic [TRAILER_LIMIT_W-1:0] lim_trailer = TRAILER_LIMIT_RST;
    logic [SKIP_LIMIT_W-1:0]    lim_skip    = SKIP_LIMIT_RST;

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic void start_line();
        size_acc = '0;
        line_len = 0;
        lflags   = '0;
    endfunction

    function automatic void clear_decoder();
        ph         = PH_SIZE_FIRST;
        chunk_left = '0;
        start_line();
    endfunction

    function automatic bit line_empty();
        return line_len == 0 || (line_len == 1 && lflags.leadcr);
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_CR;
    endfunction

    function automatic int hex_digit_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    // Applies one accepted byte and queues the result it should give
    function automatic void decode_byte(logic [7:0] c, logic sb);
        int      v;
        bit      give;
        t_result r;
        give = 1'b0;
        r    = '{kind: KIND_PAYLOAD, payload: 8'h00, fault: FAULT_NONE};
        if (sb) clear_decoder();
        sent_items++;
        case (ph)
            PH_SIZE_FIRST, PH_SIZE_SECOND: begin
                if (c == CH_LF) begin
                    if (ph == PH_SIZE_FIRST && line_empty()) begin
                        ph = PH_SIZE_SECOND;
                    end else if (size_acc == 0) begin
                        ph = PH_TRAILER;
                    end else begin
                        chunk_left = size_acc;
                        ph         = PH_DATA;
                    end
                    start_line();
                end else if (line_len >= lim_size) begin
                    give    = 1'b1;
                    r.fault = FAULT_LINE_LONG;
                end else begin
                    line_len++;
                    if (!lflags.ext) begin
                        if (c == CH_SEMI) begin
                            lflags.ext = 1'b1;
                        end else if (is_blank(c)) begin
                            if (lflags.digit) lflags.tail = 1'b1;
                            else if (line_len == 1 && c == CH_CR) lflags.leadcr = 1'b1;
                        end else begin
                            v = hex_digit_value(c);
                            if (v < 0 || lflags.tail) begin
                                give    = 1'b1;
                                r.fault = FAULT_BAD_HEX;
                            end else if ((size_acc >> (SIZE_BITS - 4)) != 0) begin
                                give    = 1'b1;
                                r.fault = FAULT_OVERFLOW;
                            end else begin
                                size_acc     = (size_acc << 4) | 64'(v);
                                lflags.digit = 1'b1;
                            end
                        end
                    end
                end
            end
            PH_DATA: begin
                chunk_left = chunk_left - 1;
                if (chunk_left == 0) begin
                    ph = PH_SKIP;
                    start_line();
                end
                give      = 1'b1;
                r.payload = c;
            end
            PH_SKIP: begin
                if (c == CH_LF) begin
                    ph = PH_SIZE_FIRST;
                    start_line();
                end else if (line_len >= lim_skip) begin
                    give    = 1'b1;
                    r.fault = FAULT_LINE_LONG;
                end else begin
                    line_len++;
                end
            end
            PH_TRAILER: begin
                if (c == CH_LF) begin
                    if (line_empty()) begin
                        ph     = PH_DONE;
                        give   = 1'b1;
                        r.kind = KIND_DONE;
                    end
                    start_line();
                end else if (line_len >= lim_trailer) begin
                    give    = 1'b1;
                    r.fault = FAULT_LINE_LONG;
                end else begin
                    line_len++;
                    if (line_len == 1 && c == CH_CR) lflags.leadcr = 1'b1;
                end
            end
            default: ;
        endcase
        // every fault ends the body
        if (give && r.fault != FAULT_NONE) begin
            ph     = PH_FAILED;
            r.kind = KIND_ERROR;
        end
        if (give) due_results.insert(due_results.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------
    function automatic void begin_body();
        next_start = 1'b1;
    endfunction

    function automatic void add_byte(logic [7:0] b);
        t_body_req req;
        req.b = b;
        req.s = next_start;
        pending.insert(pending.size(), req);
        next_start = 1'b0;
    endfunction

    function automatic void add_text(string txt);
        for (int i = 0; i < txt.len(); i++) add_byte(txt[i]);
    endfunction

    function automatic void add_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    // Line end, mostly CRLF
    function automatic void add_eol();
        if ($urandom_range(3, 0) == 0) add_byte(CH_LF);
        else add_crlf();
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(2, 0))
            0:       return CH_SP;
            1:       return CH_TAB;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(255, 0));
        if (c == CH_LF) c = 8'h00;
        return c;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 10) return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // Hex size with random letter case and optional leading zeros
    function automatic void add_size(logic [35:0] sz, int zeros);
        int nd;
        nd = 1;
        while (nd < 9 && (sz >> (4 * nd)) != 0) nd++;
        repeat (zeros) add_byte("0");
        for (int i = nd - 1; i >= 0; i--) add_byte(hex_char(sz[4*i +: 4], $urandom_range(1, 0)));
    endfunction

    // One random body: mostly well formed, some broken, some noise
    function automatic void build_random_body();
        int          head;
        int          pick;
        int          idx;
        logic [31:0] sz;
        head = pending.size();
        begin_body();
        pick = $urandom_range(19, 0);
        if (pick == 0) begin
            repeat ($urandom_range(24, 1)) add_byte(8'($urandom_range(255, 0)));
            return;
        end
        repeat ($urandom_range(3, 0)) begin
            if ($urandom_range(7, 0) == 0) add_eol();
            if ($urandom_range(5, 0) == 0) add_byte(blank_char());
            sz = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
            add_size(36'(sz), $urandom_range(3, 0) == 0 ? $urandom_range(2, 1) : 0);
            if ($urandom_range(5, 0) == 0) add_byte(blank_char());
            if ($urandom_range(4, 0) == 0) begin
                add_byte(CH_SEMI);
                repeat ($urandom_range(4, 0)) add_byte(text_char());
            end
            add_eol();
            repeat (sz) add_byte(8'($urandom_range(255, 0)));
            if ($urandom_range(3, 0) == 0) repeat ($urandom_range(3, 1)) add_byte(text_char());
            add_eol();
        end
        // closing chunk, or a huge or overflowing size that is abandoned
        pick = $urandom_range(15, 0);
        if (pick == 0) begin
            add_size(36'($urandom_range(32'hFFFF_FFFF, 32'h1000_0000)), 0);
            add_eol();
            repeat ($urandom_range(3, 0)) add_byte(8'($urandom_range(255, 0)));
            return;
        end else if (pick == 1) begin
            add_size({4'($urandom_range(15, 1)), 32'($urandom_range(32'hFFFF_FFFF, 0))}, 0);
        end else if (pick <= 3) begin
            add_eol();
            add_eol();
        end else begin
            add_size(36'd0, $urandom_range(2, 0));
            if ($urandom_range(3, 0) == 0) begin
                add_byte(CH_SEMI);
                add_text("end");
            end
            add_eol();
        end
        repeat ($urandom_range(2, 0)) begin
            add_text("X-c:");
            repeat ($urandom_range(5, 0)) add_byte(8'($urandom_range(126, 32)));
            add_eol();
        end
        add_eol();
        // corruption, restart mid-body, trailing bytes that must be swallowed
        if ($urandom_range(5, 0) == 0 && pending.size() > head + 1) begin
            idx = $urandom_range(pending.size() - 1, head + 1);
            pending[idx].b = 8'($urandom_range(255, 0));
        end
        if ($urandom_range(11, 0) == 0 && pending.size() > head + 1) begin
            idx = $urandom_range(pending.size() - 1, head + 1);
            pending[idx].s = 1'b1;
        end
        if ($urandom_range(3, 0) == 0) repeat ($urandom_range(3, 1)) add_byte(text_char());
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    task automatic send_stream();
        int        gap;
        t_body_req req;
        while (pending.size() != 0) begin
            req = pending.pop_front();
            gap = $urandom_range(tx_idle_max, 0);
            if (gap > 0) begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            byte_valid <= 1'b1;
            byte_data  <= req.b;
            byte_start <= req.s;
            @(posedge i_clk);
            while (!byte_ready) @(posedge i_clk);
            decode_byte(req.b, req.s);
        end
    endtask

    // Drop valid, let every expected result arrive, then let the pipe empty
    task automatic wait_idle();
        byte_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SIZE_LIMIT:    lim_size    = val[SIZE_LIMIT_W-1:0];
            REG_TRAILER_LIMIT: lim_trailer = val[TRAILER_LIMIT_W-1:0];
            REG_SKIP_LIMIT:    lim_skip    = val[SKIP_LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(int size_lim, int trailer_lim, int skip_lim);
        apb_write(REG_SIZE_LIMIT, size_lim);
        apb_write(REG_TRAILER_LIMIT, trailer_lim);
        apb_write(REG_SKIP_LIMIT, skip_lim);
    endtask

    // Result sink: random ready gaps, plus one long hold when requested
    initial begin : result_sink
        int gap;
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                gap         = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = $urandom_range(rx_idle_max, 0);
            end
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ready <= 1'b1;
            @(posedge i_clk);
            while (!(res_valid && res_ready)) @(posedge i_clk);
        end
    end

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && res_valid && res_ready) begin
            if (due_results.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] unexpected result kind=%0d payload=%02h fault=%0d",
                             $realtime, res_kind, res_payload, res_fault);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (res_kind !== want.kind || res_payload !== want.payload
                        || res_fault !== want.fault) begin
                    if (mismatches < 10)
                        $display("[%0t] exp k=%0d p=%02h f=%0d, got k=%0d p=%02h f=%0d",
                                 $realtime, want.kind, want.payload, want.fault,
                                 res_kind, res_payload, res_fault);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Leading empty line, blanks, extension, unchecked chunk tail, trailer, swallow after end
    task automatic test_well_formed();
        tx_idle_max = 11;
        rx_idle_max = 11;
        begin_body();
        add_crlf();
        add_byte(CH_TAB);
        add_text("2");
        add_byte(CH_SP);
        add_text(";n=v");
        add_crlf();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("zz");
        add_byte(CH_LF);
        add_text("0a");
        add_crlf();
        add_byte(CH_LF);
        add_byte(CH_CR);
        add_byte(CH_SEMI);
        add_text("0UA");
        add_byte(8'h7F);
        add_byte(8'h80);
        add_byte(8'h01);
        add_byte(8'hFE);
        add_crlf();
        add_text("0");
        add_crlf();
        add_text("X-T: 1");
        add_crlf();
        add_crlf();
        add_text("5");
        add_byte(CH_LF);
        send_stream();
        wait_idle();
    endtask

    // Bad digit, digit after trailing blank, size overflow, largest size, empty size
    task automatic test_bad_input();
        begin_body();
        add_text("g1");
        begin_body();
        add_text("1 2");
        begin_body();
        add_text("100000000");
        begin_body();
        add_text("FFFFFFFF");
        add_crlf();
        add_text("AB");
        begin_body();
        add_byte(CH_LF);
        add_byte(CH_LF);
        add_byte(CH_CR);
        add_byte(CH_LF);
        send_stream();
        wait_idle();
    endtask

    // Lines at and just over the smallest limits
    task automatic test_line_limits();
        set_limits(1, 1, 1);
        begin_body();
        add_text("1");
        add_byte(CH_LF);
        add_byte(8'h33);
        add_byte(CH_LF);
        add_text("0");
        add_byte(CH_LF);
        add_text("t");
        add_byte(CH_LF);
        add_byte(CH_LF);
        begin_body();
        add_text("12");
        begin_body();
        add_text("1");
        add_byte(CH_LF);
        add_byte(8'h00);
        add_text("ab");
        begin_body();
        add_text("0");
        add_byte(CH_LF);
        add_text("ab");
        send_stream();
        wait_idle();
    endtask

    // Long chunk while the result side holds off: the input must stall
    task automatic test_backpressure();
        set_limits(SIZE_LIMIT_RST, TRAILER_LIMIT_RST, SKIP_LIMIT_RST);
        tx_idle_max = 0;
        rx_idle_max = 0;
        hold_cycles = HOLD_LEN;
        begin_body();
        add_text("80");
        add_crlf();
        repeat (128) add_byte(8'($urandom_range(255, 0)));
        add_crlf();
        add_text("0");
        add_crlf();
        add_crlf();
        send_stream();
        wait_idle();
    endtask

    // Random bodies under several limit settings, with and without idling
    task automatic test_random();
        int goal;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_limits(4096, 8192, 64);
                1: set_limits($urandom_range(12, 2), $urandom_range(10, 1), $urandom_range(4, 1));
                2: set_limits(1, 1, 1);
                default: set_limits($urandom_range(4096, 1), $urandom_range(8192, 1),
                                    $urandom_range(64, 1));
            endcase
            goal = sent_items + 240;
            while (sent_items < goal) begin
                if ($urandom_range(3, 0) == 0) begin
                    tx_idle_max = 0;
                    rx_idle_max = 0;
                end else begin
                    tx_idle_max = 11;
                    rx_idle_max = 11;
                end
                build_random_body();
                send_stream();
            end
            wait_idle();
        end
    endtask

    initial begin
        clear_decoder();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_well_formed();
        test_bad_input();
        test_line_limits();
        test_backpressure();
        test_random();
        wait_idle();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
